// ----- rtl/core/macd_pkg.sv -----
// Shared types, constants and widths of the MACD indicator block.
package macd_pkg;

  // Fixed field widths of the channels.
  localparam int unsigned PRICE_W   = 32;
  localparam int unsigned PERIOD_W  = 8;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned DIFF_W    = 49;
  localparam int unsigned BAR_W     = 51;

  // Default number of fraction bits carried by the averages.
  localparam int unsigned FRACTION_BITS_DEF = 16;

  // Divisor is period + 1, at most 256, so it needs nine bits.
  localparam int unsigned DIVISOR_W = PERIOD_W + 1;

  // Quotient bits retired by the divider in each cycle.
  localparam int unsigned DIV_BITS = 4;

  // Period registers after reset.
  localparam logic [PERIOD_W-1:0] SHORT_PERIOD_RST  = 8'd12;
  localparam logic [PERIOD_W-1:0] LONG_PERIOD_RST   = 8'd26;
  localparam logic [PERIOD_W-1:0] SIGNAL_PERIOD_RST = 8'd9;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SHORT  = 2'd0,
    CFG_LONG   = 2'd1,
    CFG_SIGNAL = 2'd2
  } macd_cfg_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SUM,
    ST_SUB,
    ST_DSTART,
    ST_DWAIT,
    ST_DONE
  } macd_state_e;

  // The average that the shared datapath is working on.
  typedef enum logic [1:0] {
    LANE_FAST,
    LANE_SLOW,
    LANE_SIG
  } macd_lane_e;

  // Stage enables of the numerator unit.
  typedef struct packed {
    logic mul_en;
    logic sum_en;
    logic sub_en;
  } numer_ctl_t;

endpackage

// ----- rtl/core/macd_if.sv -----
// Handshake channel interfaces of the MACD indicator block.
interface macd_in_if import macd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [PRICE_W-1:0] close_price;
  logic               first_sample;

  modport source (output valid, close_price, first_sample, input ready);
  modport sink (input valid, close_price, first_sample, output ready);
endinterface

interface macd_out_if import macd_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DIFF_W-1:0] diff_line;
  logic signed [DIFF_W-1:0] dea_line;
  logic signed [BAR_W-1:0]  macd_bar;

  modport source (output valid, diff_line, dea_line, macd_bar, input ready);
  modport sink (input valid, diff_line, dea_line, macd_bar, output ready);
endinterface

interface macd_cfg_if import macd_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [PERIOD_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/core/macd_numer.sv -----
// Numerator unit: forms |2*x +/- (N-1)*y| and its sign over three stages.
module macd_numer import macd_pkg::*; #(
  parameter int unsigned FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                                  clk_i,
  input  numer_ctl_t                            ctl_i,
  input  logic [PRICE_W+FRACTION_BITS-1:0]      x_mag_i,
  input  logic                                  x_neg_i,
  input  logic [PRICE_W+FRACTION_BITS-1:0]      y_mag_i,
  input  logic                                  y_neg_i,
  input  logic [PERIOD_W-1:0]                   scale_i,
  output logic [PRICE_W+FRACTION_BITS+PERIOD_W-1:0] num_o,
  output logic                                  neg_o
);

  localparam int unsigned MAG_W = PRICE_W + FRACTION_BITS;
  localparam int unsigned NUM_W = MAG_W + PERIOD_W;

  logic [NUM_W-1:0] prod_q;
  logic [NUM_W-1:0] pos_q;
  logic [NUM_W-1:0] neg_q;
  logic [NUM_W-1:0] num_q;
  logic             sign_q;
  logic [NUM_W-1:0] tx;
  logic [NUM_W-1:0] pos_d;
  logic [NUM_W-1:0] neg_d;

  // Twice the new sample, and the positive and negative partial sums.
  always_comb begin
    tx    = NUM_W'({x_mag_i, 1'b0});
    pos_d = (x_neg_i ? '0 : tx) + (y_neg_i ? '0 : prod_q);
    neg_d = (x_neg_i ? tx : '0) + (y_neg_i ? prod_q : '0);
  end

  // Multiply, sum and magnitude stages, one per sequencer step.
  always_ff @(posedge clk_i) begin
    if (ctl_i.mul_en) begin
      prod_q <= scale_i * y_mag_i;
    end
    if (ctl_i.sum_en) begin
      pos_q <= pos_d;
      neg_q <= neg_d;
    end
    if (ctl_i.sub_en) begin
      if (pos_q >= neg_q) begin
        num_q  <= pos_q - neg_q;
        sign_q <= 1'b0;
      end else begin
        num_q  <= neg_q - pos_q;
        sign_q <= 1'b1;
      end
    end
  end

  assign num_o = num_q;
  assign neg_o = sign_q;

endmodule

// ----- rtl/core/macd_div.sv -----
// Iterative restoring divider that retires DIV_BITS quotient bits per cycle.
module macd_div import macd_pkg::*; #(
  parameter int unsigned NUM_W = PRICE_W + FRACTION_BITS_DEF + PERIOD_W
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [NUM_W-1:0]     dividend_i,
  input  logic [DIVISOR_W-1:0] divisor_i,
  output logic [NUM_W-1:0]     quot_o,
  output logic                 done_o
);

  localparam int unsigned STEPS = (NUM_W + DIV_BITS - 1) / DIV_BITS;
  localparam int unsigned PAD_W = STEPS * DIV_BITS;
  localparam int unsigned CNT_W = $clog2(STEPS);
  localparam int unsigned REM_W = DIVISOR_W - 1;

  logic [PAD_W-1:0] shift_q, shift_d;
  logic [REM_W-1:0] rem_q, rem_d;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic             done_q;

  // Several shift and subtract steps on the narrow remainder.
  always_comb begin
    logic [REM_W-1:0] r;
    logic [PAD_W-1:0] s;
    logic [REM_W:0]   t;
    r = rem_q;
    s = shift_q;
    for (int i = 0; i < DIV_BITS; i++) begin
      t = {r, s[PAD_W-1]};
      s = {s[PAD_W-2:0], 1'b0};
      if (t >= divisor_i) begin
        r    = REM_W'(t - divisor_i);
        s[0] = 1'b1;
      end else begin
        r = t[REM_W-1:0];
      end
    end
    rem_d   = r;
    shift_d = s;
  end

  // Control: step counter, busy flag and a one-cycle done pulse.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(STEPS - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: dividend shifts out on top while quotient bits enter below.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      shift_q <= PAD_W'(dividend_i);
      rem_q   <= '0;
    end else if (busy_q) begin
      shift_q <= shift_d;
      rem_q   <= rem_d;
    end
  end

  assign quot_o = shift_q[NUM_W-1:0];
  assign done_o = done_q;

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni) start_i |-> !busy_q)
    else $error("divider started while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && (cnt_q == '0) |=> done_q && !busy_q)
    else $error("divider did not finish after its last step");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> ({1'b0, rem_q} < divisor_i))
    else $error("divider remainder not below divisor");
`endif

endmodule

// ----- rtl/core/macd_indicator.sv -----
// Top level of the MACD indicator: sequencer, averages and result register.
//
// One closing price per transaction updates a fast and a slow exponential
// average of the price and an average of their difference, each of period N
// computed as (2*x + (N-1)*y) / (N+1) with truncation, and returns DIFF, DEA
// and the bar 2*(DIFF-DEA) with FRACTION_BITS fraction bits. The three
// updates run one after another through one multiplier, one add/subtract
// stage and one iterative divider that retires four quotient bits a cycle.
// A normal item keeps the input busy until its three updates are done; an
// item that seeds the averages (first_sample set, or the first after
// reset) skips them and goes straight to the result. The result register
// lets the next item be accepted while a result still waits; a finished
// item waits only if that register is still full. Configuration
// transactions are accepted only while the block is idle and no input
// transaction is offered; they take effect on the next item and do not
// reseed the averages.
module macd_indicator import macd_pkg::*; #(
  parameter int unsigned FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  macd_cfg_if.sink   cfg_i,
  macd_in_if.sink    in_i,
  macd_out_if.source out_o
);

  localparam int unsigned MAG_W  = PRICE_W + FRACTION_BITS;
  localparam int unsigned AVG_W  = MAG_W + 1;
  localparam int unsigned NUM_W  = MAG_W + PERIOD_W;
  localparam int unsigned BDIF_W = AVG_W + 1;
  localparam int unsigned BAR2_W = AVG_W + 2;

  macd_state_e state_q, state_d;
  macd_lane_e  lane_q;
  logic        seeded_q;

  logic [PERIOD_W-1:0] short_q, long_q, signal_q;

  logic [MAG_W-1:0]        x_q;
  logic [MAG_W-1:0]        fast_q;
  logic [MAG_W-1:0]        slow_q;
  logic signed [AVG_W-1:0] sig_q;

  logic                     out_valid_q;
  logic signed [DIFF_W-1:0] diff_out_q, dea_out_q;
  logic signed [BAR_W-1:0]  bar_out_q;

  logic                 in_ready;
  logic                 in_accept;
  logic                 seed_now;
  logic                 out_load;
  numer_ctl_t           numer_ctl;
  logic                 div_start;
  logic                 div_done;
  logic [NUM_W-1:0]     div_quot;
  logic [NUM_W-1:0]     num;
  logic                 num_neg;

  logic [PERIOD_W-1:0]  period;
  logic [PERIOD_W-1:0]  scale;
  logic [DIVISOR_W-1:0] divisor;
  logic [MAG_W-1:0]     x_mag, y_mag;
  logic                 x_neg, y_neg;

  logic signed [AVG_W-1:0]  diff_s;
  logic signed [BDIF_W-1:0] bar_s;
  logic signed [BAR2_W-1:0] bar2_s;
  logic [MAG_W-1:0]         quot_mag;
  logic signed [AVG_W-1:0]  sig_new;

  // Configuration registers; a transaction is taken only between items.
  assign cfg_i.ready = (state_q == ST_IDLE) && !in_i.valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      short_q  <= SHORT_PERIOD_RST;
      long_q   <= LONG_PERIOD_RST;
      signal_q <= SIGNAL_PERIOD_RST;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (macd_cfg_e'(cfg_i.index))
        CFG_SHORT:  short_q  <= cfg_i.data;
        CFG_LONG:   long_q   <= cfg_i.data;
        CFG_SIGNAL: signal_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  assign in_accept = in_i.valid && in_ready;
  assign seed_now  = in_i.first_sample || !seeded_q;
  assign out_load  = (state_q == ST_DONE) && (!out_valid_q || out_o.ready);

  // Difference line and bar from the current averages.
  assign diff_s = $signed({1'b0, fast_q}) - $signed({1'b0, slow_q});
  assign bar_s  = BDIF_W'(diff_s) - BDIF_W'(sig_q);
  assign bar2_s = $signed({bar_s, 1'b0});

  // Operands of the shared datapath for the average being updated.
  always_comb begin
    case (lane_q)
      LANE_FAST: begin
        period = short_q;
        x_mag  = x_q;
        x_neg  = 1'b0;
        y_mag  = fast_q;
        y_neg  = 1'b0;
      end
      LANE_SLOW: begin
        period = long_q;
        x_mag  = x_q;
        x_neg  = 1'b0;
        y_mag  = slow_q;
        y_neg  = 1'b0;
      end
      LANE_SIG: begin
        period = signal_q;
        x_neg  = diff_s[AVG_W-1];
        x_mag  = MAG_W'(x_neg ? -diff_s : diff_s);
        y_neg  = sig_q[AVG_W-1];
        y_mag  = MAG_W'(y_neg ? -sig_q : sig_q);
      end
      default: begin
        period = '0;
        x_mag  = '0;
        x_neg  = 1'b0;
        y_mag  = '0;
        y_neg  = 1'b0;
      end
    endcase
  end

  // A period of zero behaves as a period of one.
  always_comb begin
    if (period == '0) begin
      scale   = '0;
      divisor = DIVISOR_W'(2);
    end else begin
      scale   = period - 1'b1;
      divisor = DIVISOR_W'(period) + 1'b1;
    end
  end

  // Signed result of the division for the signal average.
  assign quot_mag = div_quot[MAG_W-1:0];
  assign sig_new  = num_neg ? -$signed({1'b0, quot_mag}) : $signed({1'b0, quot_mag});

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          state_d = seed_now ? ST_DONE : ST_MUL;
        end
      end
      ST_MUL:    state_d = ST_SUM;
      ST_SUM:    state_d = ST_SUB;
      ST_SUB:    state_d = ST_DSTART;
      ST_DSTART: state_d = ST_DWAIT;
      ST_DWAIT: begin
        if (div_done) begin
          state_d = (lane_q == LANE_SIG) ? ST_DONE : ST_MUL;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ready  = 1'b0;
    numer_ctl = '0;
    div_start = 1'b0;
    case (state_q)
      ST_IDLE:   in_ready = 1'b1;
      ST_MUL:    numer_ctl.mul_en = 1'b1;
      ST_SUM:    numer_ctl.sum_en = 1'b1;
      ST_SUB:    numer_ctl.sub_en = 1'b1;
      ST_DSTART: div_start = 1'b1;
      default: ;
    endcase
  end

  assign in_i.ready = in_ready;

  // Control state: sequencer, lane and seed flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      lane_q   <= LANE_FAST;
      seeded_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_accept) begin
        lane_q   <= LANE_FAST;
        seeded_q <= 1'b1;
      end else if ((state_q == ST_DWAIT) && div_done) begin
        case (lane_q)
          LANE_FAST: lane_q <= LANE_SLOW;
          LANE_SLOW: lane_q <= LANE_SIG;
          default:   lane_q <= LANE_FAST;
        endcase
      end
    end
  end

  // Averages: seeded on the accepting edge, updated as each division ends.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      x_q <= {in_i.close_price, {FRACTION_BITS{1'b0}}};
      if (seed_now) begin
        fast_q <= {in_i.close_price, {FRACTION_BITS{1'b0}}};
        slow_q <= {in_i.close_price, {FRACTION_BITS{1'b0}}};
        sig_q  <= '0;
      end
    end else if ((state_q == ST_DWAIT) && div_done) begin
      case (lane_q)
        LANE_FAST: fast_q <= quot_mag;
        LANE_SLOW: slow_q <= quot_mag;
        LANE_SIG:  sig_q  <= sig_new;
        default: ;
      endcase
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      diff_out_q <= DIFF_W'(diff_s);
      dea_out_q  <= DIFF_W'(sig_q);
      bar_out_q  <= BAR_W'(bar2_s);
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.diff_line = diff_out_q;
  assign out_o.dea_line  = dea_out_q;
  assign out_o.macd_bar  = bar_out_q;

  // Shared numerator unit.
  macd_numer #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_numer (
    .clk_i   (clk_i),
    .ctl_i   (numer_ctl),
    .x_mag_i (x_mag),
    .x_neg_i (x_neg),
    .y_mag_i (y_mag),
    .y_neg_i (y_neg),
    .scale_i (scale),
    .num_o   (num),
    .neg_o   (num_neg)
  );

  // Shared divider.
  macd_div #(
    .NUM_W(NUM_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (num),
    .divisor_i  (divisor),
    .quot_o     (div_quot),
    .done_o     (div_done)
  );

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni) in_accept |=> !in_i.ready)
    else $error("input taken again right after a transaction");
  assert property (@(posedge clk_i) disable iff (!rst_ni) !$fell(seeded_q))
    else $error("seed flag cleared outside reset");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_DONE))
    else $error("result loaded outside the done state");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DWAIT) && div_done && (lane_q == LANE_SIG) |=> (state_q == ST_DONE))
    else $error("sequencer skipped the result after the last average");
`endif

endmodule
